@@ src/dpr_pkg.sv @@
package dpr_pkg;

	localparam int IMAGE_WIDTH  = 2048;
	localparam int IMAGE_HEIGHT = 2048;

	localparam int COORD_W   = 11;
	localparam int CMP_W     = 14;   // holds any image size up to 8192
	localparam int PIX_W     = 22;
	localparam int CNT_W     = 22;
	localparam int W_W       = 49;   // d*Q32 + 16*Q32, signed
	localparam int NUM_W     = 33;   // x*2^16 + Q32, signed
	localparam int QUO_W     = 31;   // unsaturated quotient magnitude
	localparam int DVD_W     = NUM_W + 32;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		REG_CENTER_X   = 4'd0,
		REG_CENTER_Y   = 4'd1,
		REG_FOCAL      = 4'd2,
		REG_INV_BASE   = 4'd3,
		REG_OFFSET     = 4'd4,
		REG_ROI_BOX    = 4'd5,
		REG_DEPTH_WIN  = 4'd6,
		REG_CONTROL    = 4'd7
	} reg_idx_t;

	localparam logic [63:0] DEPTH_WIN_RESET = 64'h0037_8000_0000_0000;
	localparam logic [17:0] CONTROL_RESET   = 18'd3;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] focal;
		logic signed [31:0] inv_baseline;
		logic signed [31:0] offset;
		logic [63:0]        roi_box;
		logic [63:0]        depth_window;
		logic [17:0]        control;
	} dpr_cfg_t;

	typedef struct packed {
		logic                  keep;
		logic                  frame_start;
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		logic signed [W_W-1:0] w;
		logic [23:0]           color;
		logic [PIX_W-1:0]      pix;
	} dpr_entry_t;

endpackage

@@ src/dpr_front.sv @@
module dpr_front import dpr_pkg::*; (
	input  dpr_cfg_t           cfg,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic signed [15:0] disparity,
	input  logic [7:0]         blue,
	input  logic [7:0]         green,
	input  logic [7:0]         red,
	input  logic               frame_start,
	output dpr_entry_t         entry
);

	logic              in_image, roi_on, in_roi, disp_ok;
	logic [15:0]       rx0, ry0, rw, rh;
	logic signed [15:0] min_disp;
	logic signed [19:0] min_scaled;
	logic signed [47:0] prod;

	always_comb begin
		rx0 = cfg.roi_box[15:0];
		ry0 = cfg.roi_box[31:16];
		rw  = cfg.roi_box[47:32];
		rh  = cfg.roi_box[63:48];
		in_image = ({{(CMP_W-COORD_W){1'b0}}, pixel_x} < CMP_W'(IMAGE_WIDTH))
			&& ({{(CMP_W-COORD_W){1'b0}}, pixel_y} < CMP_W'(IMAGE_HEIGHT));
		roi_on = cfg.control[0] && (rw != 16'd0) && (rh != 16'd0);
		in_roi = ({5'd0, pixel_x} >= rx0)
			&& ({6'd0, pixel_x} < ({1'b0, rx0} + {1'b0, rw}))
			&& ({5'd0, pixel_y} >= ry0)
			&& ({6'd0, pixel_y} < ({1'b0, ry0} + {1'b0, rh}));
		min_disp   = signed'(cfg.control[17:2]);
		min_scaled = {min_disp, 4'd0};
		disp_ok    = (20'(disparity) >= min_scaled) && (disparity != 16'sd0);
		prod = disparity * cfg.inv_baseline;

		entry.keep        = in_image && (!roi_on || in_roi) && disp_ok;
		entry.frame_start = frame_start;
		entry.x           = pixel_x;
		entry.y           = pixel_y;
		entry.w           = {prod[47], prod}
			+ {{(W_W-36){cfg.offset[31]}}, cfg.offset, 4'd0};
		entry.color       = {red, green, blue};
		entry.pix         = PIX_W'({{(PIX_W-COORD_W){1'b0}}, pixel_y} * PIX_W'(IMAGE_WIDTH))
			+ PIX_W'(pixel_x);
	end

endmodule

@@ src/dpr_queue.sv @@
module dpr_queue import dpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  dpr_entry_t wr_entry,
	output logic       q_full,
	input  logic       rd,
	output dpr_entry_t rd_entry,
	output logic       q_empty
);

	dpr_entry_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QPTR_W:0]    count_q;

	assign q_full   = (count_q == (QPTR_W+1)'(QDEPTH));
	assign q_empty  = (count_q == '0);
	assign rd_entry = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr && !q_full) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr && !q_full) wptr_q <= wptr_q + 1'b1;
			if (rd && !q_empty) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (QPTR_W+1)'(wr && !q_full) - (QPTR_W+1)'(rd && !q_empty);
		end
	end

endmodule

@@ src/dpr_back.sv @@
module dpr_back import dpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dpr_cfg_t           cfg,
	input  logic               q_empty,
	input  dpr_entry_t         q_entry,
	output logic               q_pop,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic [23:0]        packed_color,
	output logic [PIX_W-1:0]   source_pixel,
	output logic [CNT_W-1:0]   point_number,
	output logic               empty,
	input  logic               pop
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [W_W-1:0]      den_q;
	logic [W_W-1:0]      rem_q [3];
	logic [DVD_W-1:0]    dvd_q [3];
	logic [QUO_W-1:0]    quo_q [3];
	logic                sat_q [3];
	logic                neg_q [3];
	logic [23:0]         color_q;
	logic [PIX_W-1:0]    pix_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;

	logic signed [NUM_W-1:0] num [3];
	logic [NUM_W-1:0]        num_mag [3];
	logic [W_W-1:0]          w_mag;
	logic [W_W:0]            trial [3];
	logic                    ge [3];
	logic signed [31:0]      res [3];
	logic                    z_ok, slot_free, out_load;

	always_comb begin
		num[0] = signed'({1'b0, q_entry.x, 16'd0}) + NUM_W'(cfg.center_x);
		num[1] = signed'({1'b0, q_entry.y, 16'd0}) + NUM_W'(cfg.center_y);
		num[2] = NUM_W'(cfg.focal);
		w_mag  = q_entry.w[W_W-1] ? W_W'(-q_entry.w) : W_W'(q_entry.w);
	end

	// three lanes share the divisor and step together
	for (genvar i = 0; i < 3; i++) begin : g_lane
		always_comb begin
			num_mag[i] = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
			trial[i]   = {rem_q[i], dvd_q[i][DVD_W-1]};
			ge[i]      = trial[i] >= {1'b0, den_q};
			if (sat_q[i]) begin
				res[i] = neg_q[i] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end else if (neg_q[i]) begin
				res[i] = -signed'({1'b0, quo_q[i]});
			end else begin
				res[i] = signed'({1'b0, quo_q[i]});
			end
		end
	end

	assign z_ok = !cfg.control[1]
		|| ((res[2] >= signed'(cfg.depth_window[31:0]))
		&& (res[2] <= signed'(cfg.depth_window[63:32])));
	assign slot_free = !out_valid_q || pop;
	assign out_load  = (state_q == ST_DONE) && z_ok && slot_free;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				den_q   <= w_mag;
				color_q <= q_entry.color;
				pix_q   <= q_entry.pix;
				step_q  <= '0;
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= '0;
					dvd_q[i] <= {num_mag[i], 32'd0};
					quo_q[i] <= '0;
					sat_q[i] <= 1'b0;
					neg_q[i] <= num[i][NUM_W-1] ^ q_entry.w[W_W-1];
				end
			end
			ST_DIV: begin
				step_q <= step_q + 1'b1;
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= ge[i] ? W_W'(trial[i] - {1'b0, den_q}) : W_W'(trial[i]);
					dvd_q[i] <= {dvd_q[i][DVD_W-2:0], 1'b0};
					quo_q[i] <= {quo_q[i][QUO_W-2:0], ge[i]};
					sat_q[i] <= sat_q[i] | quo_q[i][QUO_W-1];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			point_x      <= res[0];
			point_y      <= res[1];
			point_z      <= res[2];
			packed_color <= color_q;
			source_pixel <= pix_q;
			point_number <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !pop);
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_entry.frame_start) cnt_q <= '0;
						if (q_entry.keep && q_entry.w != '0) state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS-1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!z_ok) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/disparity_to_point_reprojector_core.sv @@
// disparity to 3d point reprojector
// input side: a queue face. an item is taken at a clock edge where push is
// high and full is low; it carries pixel coordinates, a signed q12.4
// disparity, the bgr color and a frame_start mark
// result side: while empty is low the oldest point sits on the result ports;
// it leaves at an edge where pop is high. dropped pixels give no item
// configuration: wr_en, wr_index, wr_data write one register per edge; the
// user writes only while the block is idle, which the block does not enforce
// a kept item passes the queue write, the load, 65 divider steps and the
// finish before it reaches the output register; an item dropped in the front
// is popped in the idle state, one dropped by the z window runs all the steps
// the bit-serial divider takes a new item only once it is through with the
// last; it forms x, y and z in three lanes, one quotient bit per cycle each
// the 4-deep item queue keeps accepting while the divider is busy
// a finished point waits in the output register while pop is low; the
// divider then holds in its finish state and the queue fills up to full
// reset: queue and output register empty, point counter zero, registers
// take their reset values (z window 0..55.5, roi and z window enabled)
module disparity_to_point_reprojector_core import dpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// config port
	input  logic               wr_en,
	input  logic [3:0]         wr_index,
	input  logic [63:0]        wr_data,
	// item input
	input  logic               push,
	output logic               full,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic signed [15:0] disparity,
	input  logic [7:0]         blue,
	input  logic [7:0]         green,
	input  logic [7:0]         red,
	input  logic               frame_start,
	// point output
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic [23:0]        packed_color,
	output logic [PIX_W-1:0]   source_pixel,
	output logic [CNT_W-1:0]   point_number
);

	dpr_cfg_t   cfg_q;
	dpr_entry_t front_entry, q_entry;
	logic       q_full, q_empty, q_pop;

	// register file, written directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x     <= '0;
			cfg_q.center_y     <= '0;
			cfg_q.focal        <= '0;
			cfg_q.inv_baseline <= '0;
			cfg_q.offset       <= '0;
			cfg_q.roi_box      <= '0;
			cfg_q.depth_window <= DEPTH_WIN_RESET;
			cfg_q.control      <= CONTROL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X:  cfg_q.center_x     <= wr_data[31:0];
				REG_CENTER_Y:  cfg_q.center_y     <= wr_data[31:0];
				REG_FOCAL:     cfg_q.focal        <= wr_data[31:0];
				REG_INV_BASE:  cfg_q.inv_baseline <= wr_data[31:0];
				REG_OFFSET:    cfg_q.offset       <= wr_data[31:0];
				REG_ROI_BOX:   cfg_q.roi_box      <= wr_data;
				REG_DEPTH_WIN: cfg_q.depth_window <= wr_data;
				REG_CONTROL:   cfg_q.control      <= wr_data[17:0];
				default: begin
				end
			endcase
		end
	end

	// front: bounds, roi and disparity checks plus the w product
	dpr_front u_front (
		.cfg         (cfg_q),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.disparity   (disparity),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.frame_start (frame_start),
		.entry       (front_entry)
	);

	// dropped items still travel so frame_start clears the counter in order
	dpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (push),
		.wr_entry (front_entry),
		.q_full   (q_full),
		.rd       (q_pop),
		.rd_entry (q_entry),
		.q_empty  (q_empty)
	);

	assign full = q_full;

	// back: three-lane divider, z window, point counter, output register
	dpr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.packed_color (packed_color),
		.source_pixel (source_pixel),
		.point_number (point_number),
		.empty        (empty),
		.pop          (pop)
	);

endmodule

@@ src/dpr_checker.sv @@
module dpr_checker import dpr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] point_x,
	input logic [CNT_W-1:0]   point_number
);

	// reset leaves both sides open
	assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("not empty or full during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result lost without pop");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(point_x) && $stable(point_number)))
		else $error("stalled result changed");

	// the next point is either the following number or a fresh frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> (empty || point_number == $past(point_number) + 1'b1
			|| point_number == '0))
		else $error("point number skipped");

endmodule

bind disparity_to_point_reprojector_core dpr_checker u_dpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.point_x      (point_x),
	.point_number (point_number)
);
